@@ design/shs_pkg.sv @@
// Package for the SHA-256 stream hasher: word types, round constants,
// initial hash values, status and kind codes, the sequencer state type and
// the SHA-256 sigma functions. No dependencies.
package shs_pkg;

  typedef logic [31:0] word_t;
  typedef word_t hash_t [8];

  localparam int OUT_TDATA_W = 40;

  localparam logic KIND_ABSORB = 1'b0;
  localparam logic KIND_FINISH = 1'b1;

  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_FINALIZED = 2'd1;
  localparam logic [1:0] STATUS_RANGE     = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROUND,
    ST_FOLD,
    ST_PAD,
    ST_EMIT,
    ST_ERR
  } state_t;

  localparam word_t HASH_INIT [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam word_t ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic word_t big_sigma0(input word_t x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic word_t big_sigma1(input word_t x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic word_t small_sigma0(input word_t x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic word_t small_sigma1(input word_t x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
  endfunction

endpackage

@@ design/shs_round.sv @@
// One SHA-256 compression round and one message schedule step.
// Shared by all 64 rounds of a block; depends on shs_pkg.
module shs_round import shs_pkg::*; (
  input  hash_t work_in,
  input  word_t k,
  input  word_t w0,
  input  word_t w1,
  input  word_t w9,
  input  word_t w14,
  output hash_t work_out,
  output word_t w_new
);

  word_t ch;
  word_t maj;
  word_t t1;
  word_t t2;

  always_comb begin
    ch  = (work_in[4] & work_in[5]) ^ (~work_in[4] & work_in[6]);
    maj = (work_in[0] & work_in[1]) ^ (work_in[0] & work_in[2]) ^
          (work_in[1] & work_in[2]);
    t1  = work_in[7] + big_sigma1(work_in[4]) + ch + k + w0;
    t2  = big_sigma0(work_in[0]) + maj;
    work_out[0] = t1 + t2;
    work_out[1] = work_in[0];
    work_out[2] = work_in[1];
    work_out[3] = work_in[2];
    work_out[4] = work_in[3] + t1;
    work_out[5] = work_in[4];
    work_out[6] = work_in[5];
    work_out[7] = work_in[6];
    // Word t+16 of the schedule, from the 16-word window that starts at word t.
    w_new = w0 + small_sigma0(w1) + w9 + small_sigma1(w14);
  end

endmodule

@@ design/sha256_stream_hasher.sv @@
// SHA-256 stream hasher top level: byte input, digest word output.
// Depends on shs_pkg and shs_round.
//
// Input channel s_axis: tuser is the kind (0 absorb, 1 finish), tdata the
// message byte. Output channel m_axis: tuser is the status (0 digest word,
// 1 already finalized, 2 length out of range), tdata carries the digest word
// and its index, tlast marks the final item of a run.
// The byte that completes a 64-byte block starts a compression of 64 rounds
// through the single round unit, then a fold step that adds the working
// words into the hash words.
// A finish writes the padding one byte a cycle up to the end of the block,
// compresses it, and when the length does not fit, pads and compresses a
// second block. Then eight digest items follow, one per cycle while the
// receiver takes them.
// An error answers with a single item in the cycle after the input item.
// The block takes no input while it compresses, pads or has a result
// waiting; a stalled receiver simply holds the block in that state.
// Reset loads the standard initial hash values and clears the byte count and
// the finalized mark; after a finish every item gets a finalized error until
// the next reset.
module sha256_stream_hasher import shs_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [7:0]             s_axis_tdata,   // data_byte
  input  logic                   s_axis_tuser,   // kind
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // digest_word, word_index, zero fill
  output logic [1:0]             m_axis_tuser,   // status
  output logic                   m_axis_tlast    // last
);

  state_t      state, state_next;
  hash_t       hash_q;
  hash_t       work;
  hash_t       round_out;
  word_t       sched [16];
  word_t       sched_new;
  logic [5:0]  count;
  logic [63:0] total;
  logic        finalized;
  logic        padding;
  logic        pad_first;
  logic        len_block;
  logic [5:0]  rnd;
  logic [2:0]  out_idx;
  logic [1:0]  err_status;

  logic        do_absorb;
  logic        do_finish;
  logic        do_error;
  logic [1:0]  err_code;
  logic        start_round;
  logic        wr_en;
  logic [7:0]  wr_byte;
  logic [7:0]  pad_byte;
  logic [63:0] bit_len;

  shs_round u_round (
    .work_in  (work),
    .k        (ROUND_K[rnd]),
    .w0       (sched[0]),
    .w1       (sched[1]),
    .w9       (sched[9]),
    .w14      (sched[14]),
    .work_out (round_out),
    .w_new    (sched_new)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    bit_len = {total[60:0], 3'b000};
    // The length occupies the last eight bytes of the final block, high byte first.
    if (pad_first) begin
      pad_byte = 8'h80;
    end else if (len_block && count[5:3] == 3'b111) begin
      pad_byte = bit_len[{~count[2:0], 3'b000} +: 8];
    end else begin
      pad_byte = 8'h00;
    end
  end

  always_comb begin
    state_next    = state;
    s_axis_tready = 1'b0;
    m_axis_tvalid = 1'b0;
    m_axis_tdata  = '0;
    m_axis_tuser  = err_status;
    m_axis_tlast  = 1'b1;
    do_absorb     = 1'b0;
    do_finish     = 1'b0;
    do_error      = 1'b0;
    err_code      = STATUS_FINALIZED;
    start_round   = 1'b0;
    wr_en         = 1'b0;
    wr_byte       = s_axis_tdata;
    case (state)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          if (finalized) begin
            do_error   = 1'b1;
            err_code   = STATUS_FINALIZED;
            state_next = ST_ERR;
          end else if (s_axis_tuser == KIND_ABSORB) begin
            if (&total) begin
              do_error   = 1'b1;
              err_code   = STATUS_RANGE;
              state_next = ST_ERR;
            end else begin
              do_absorb = 1'b1;
              wr_en     = 1'b1;
              if (&count) begin
                start_round = 1'b1;
                state_next  = ST_ROUND;
              end
            end
          end else if (|total[63:61]) begin
            do_error   = 1'b1;
            err_code   = STATUS_RANGE;
            state_next = ST_ERR;
          end else begin
            do_finish  = 1'b1;
            state_next = ST_PAD;
          end
        end
      end
      ST_ROUND: begin
        if (&rnd) begin
          state_next = ST_FOLD;
        end
      end
      ST_FOLD: begin
        if (!padding) begin
          state_next = ST_IDLE;
        end else if (len_block) begin
          state_next = ST_EMIT;
        end else begin
          state_next = ST_PAD;
        end
      end
      ST_PAD: begin
        wr_en   = 1'b1;
        wr_byte = pad_byte;
        if (&count) begin
          start_round = 1'b1;
          state_next  = ST_ROUND;
        end
      end
      ST_EMIT: begin
        m_axis_tvalid = 1'b1;
        m_axis_tdata  = {5'd0, out_idx, hash_q[out_idx]};
        m_axis_tuser  = STATUS_OK;
        m_axis_tlast  = &out_idx;
        if (m_axis_tready && &out_idx) begin
          state_next = ST_IDLE;
        end
      end
      ST_ERR: begin
        m_axis_tvalid = 1'b1;
        if (m_axis_tready) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hash_q     <= HASH_INIT;
      count      <= '0;
      total      <= '0;
      finalized  <= 1'b0;
      padding    <= 1'b0;
      pad_first  <= 1'b0;
      len_block  <= 1'b0;
      rnd        <= '0;
      out_idx    <= '0;
      err_status <= STATUS_OK;
    end else begin
      // Bytes land big-endian in the 16-word window that later serves as the schedule.
      if (wr_en) begin
        sched[count[5:2]][{~count[1:0], 3'b000} +: 8] <= wr_byte;
        count <= count + 6'd1;
      end
      if (do_absorb) begin
        total <= total + 64'd1;
      end
      if (do_finish) begin
        finalized <= 1'b1;
        padding   <= 1'b1;
        pad_first <= 1'b1;
        len_block <= (count[5:3] != 3'b111);
      end
      if (state == ST_PAD) begin
        pad_first <= 1'b0;
      end
      if (do_error) begin
        err_status <= err_code;
      end
      if (start_round) begin
        work <= hash_q;
        rnd  <= '0;
      end
      if (state == ST_ROUND) begin
        work <= round_out;
        for (int i = 0; i < 15; i++) begin
          sched[i] <= sched[i+1];
        end
        sched[15] <= sched_new;
        rnd <= rnd + 6'd1;
      end
      if (state == ST_FOLD) begin
        for (int i = 0; i < 8; i++) begin
          hash_q[i] <= hash_q[i] + work[i];
        end
        if (padding && !len_block) begin
          len_block <= 1'b1;
        end
      end
      if (state == ST_EMIT && m_axis_tready) begin
        out_idx <= out_idx + 3'd1;
        if (&out_idx) begin
          padding <= 1'b0;
        end
      end
    end
  end

endmodule

@@ design/shs_checker.sv @@
// Port-level checks for the SHA-256 stream hasher, bound to the top level.
// Depends on shs_pkg and sha256_stream_hasher.
module shs_checker import shs_pkg::*; (
  input logic                   clk,
  input logic                   rst,
  input logic                   s_axis_tready,
  input logic                   m_axis_tvalid,
  input logic                   m_axis_tready,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata,
  input logic [1:0]             m_axis_tuser,
  input logic                   m_axis_tlast
);

  // The block never takes a new item while a result is on offer.
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(s_axis_tready && m_axis_tvalid))
    else $error("input ready while a result is pending");

  // An error result is a run of one with zero payload.
  a_error_shape: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser != STATUS_OK |->
      m_axis_tlast && m_axis_tdata == '0)
    else $error("malformed error result");

  // Digest words carry last exactly on index seven.
  a_digest_last: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser == STATUS_OK |->
      m_axis_tlast == (m_axis_tdata[34:32] == 3'd7))
    else $error("last flag does not match word index");

  // A taken digest word that is not the last is followed by the next index.
  a_digest_order: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tready && m_axis_tuser == STATUS_OK && !m_axis_tlast |=>
      m_axis_tvalid && m_axis_tuser == STATUS_OK &&
      m_axis_tdata[34:32] == $past(m_axis_tdata[34:32]) + 3'd1)
    else $error("digest words out of order");

  // A stalled result holds.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) &&
      $stable(m_axis_tlast))
    else $error("stalled result changed");

endmodule

bind sha256_stream_hasher shs_checker u_shs_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

@@ test/tb_sha256_stream_hasher.sv @@
// Testbench for sha256_stream_hasher: streams one long message, finishes it,
// checks the eight digest words against an in-bench SHA-256 predictor, then
// checks the finalized error on every later item. Depends on shs_pkg and sha256_stream_hasher.
module tb_sha256_stream_hasher;
  import shs_pkg::*;

  localparam int LONG_HOLD    = 200;
  localparam int DRAIN_CYCLES = 200;

  localparam logic [31:0] SHA_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] SHA_IV [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  typedef struct {
    logic [1:0]  status;
    logic [31:0] dword;
    logic [2:0]  index;
    logic        last;
  } digest_item_t;

  logic                   clk;
  logic                   rst;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [7:0]             s_axis_tdata;   // data_byte
  logic                   s_axis_tuser;   // kind
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;   // digest_word, word_index, zero fill
  logic [1:0]             m_axis_tuser;   // status
  logic                   m_axis_tlast;

  // Predictor state for the message being hashed.
  logic [31:0]  hash_state [8];
  logic [7:0]   block_bytes [64];
  int unsigned  fill_count;
  logic [63:0]  byte_total;
  bit           finished;

  digest_item_t pending_results [$];

  int  fail_count;
  int  results_checked;
  int  items_sent;
  int  late_items;
  bit  steady;
  bit  hold_req;
  bit  hold_active;

  sha256_stream_hasher u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  // Mostly no gap, often a short one, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic void clear_hash();
    for (int i = 0; i < 8; i++) hash_state[i] = SHA_IV[i];
    for (int i = 0; i < 64; i++) block_bytes[i] = 8'h00;
    fill_count = 0;
    byte_total = '0;
    finished   = 1'b0;
  endfunction

  function automatic void fold_block();
    logic [31:0] sched [64];
    logic [31:0] wk [8];
    logic [31:0] s0, s1, t1, t2;
    for (int i = 0; i < 16; i++) begin
      sched[i] = {block_bytes[4*i], block_bytes[4*i+1], block_bytes[4*i+2], block_bytes[4*i+3]};
    end
    for (int i = 16; i < 64; i++) begin
      s0 = rotr(sched[i-15], 7) ^ rotr(sched[i-15], 18) ^ (sched[i-15] >> 3);
      s1 = rotr(sched[i-2], 17) ^ rotr(sched[i-2], 19) ^ (sched[i-2] >> 10);
      sched[i] = sched[i-16] + s0 + sched[i-7] + s1;
    end
    for (int i = 0; i < 8; i++) wk[i] = hash_state[i];
    for (int i = 0; i < 64; i++) begin
      s1 = rotr(wk[4], 6) ^ rotr(wk[4], 11) ^ rotr(wk[4], 25);
      t1 = wk[7] + s1 + ((wk[4] & wk[5]) ^ (~wk[4] & wk[6])) + SHA_K[i] + sched[i];
      s0 = rotr(wk[0], 2) ^ rotr(wk[0], 13) ^ rotr(wk[0], 22);
      t2 = s0 + ((wk[0] & wk[1]) ^ (wk[0] & wk[2]) ^ (wk[1] & wk[2]));
      wk[7] = wk[6];
      wk[6] = wk[5];
      wk[5] = wk[4];
      wk[4] = wk[3] + t1;
      wk[3] = wk[2];
      wk[2] = wk[1];
      wk[1] = wk[0];
      wk[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) hash_state[i] = hash_state[i] + wk[i];
  endfunction

  function automatic void push_error(input logic [1:0] code);
    digest_item_t r;
    r.status = code;
    r.dword  = '0;
    r.index  = '0;
    r.last   = 1'b1;
    pending_results = {pending_results, r};
  endfunction

  // Advances the predicted hash state by one accepted item and queues
  // whatever results that item causes.
  function automatic void predict_item(input logic kind, input logic [7:0] data);
    digest_item_t r;
    logic [63:0]  bit_len;
    int           pos;
    if (finished) begin
      push_error(STATUS_FINALIZED);
      return;
    end
    if (kind == KIND_ABSORB) begin
      if (&byte_total) begin
        push_error(STATUS_RANGE);
        return;
      end
      byte_total = byte_total + 64'd1;
      block_bytes[fill_count] = data;
      fill_count = (fill_count + 1) % 64;
      if (fill_count == 0) fold_block();
      return;
    end
    // The bit length must still fit in 64 bits.
    if (byte_total > 64'h1fff_ffff_ffff_ffff) begin
      push_error(STATUS_RANGE);
      return;
    end
    finished = 1'b1;
    bit_len = byte_total << 3;
    pos = fill_count;
    block_bytes[pos] = 8'h80;
    pos++;
    // No room for the length field: pad out this block and start another.
    if (pos > 56) begin
      while (pos < 64) begin
        block_bytes[pos] = 8'h00;
        pos++;
      end
      fold_block();
      pos = 0;
    end
    while (pos < 56) begin
      block_bytes[pos] = 8'h00;
      pos++;
    end
    for (int i = 0; i < 8; i++) block_bytes[56 + i] = bit_len[63 - 8*i -: 8];
    fold_block();
    fill_count = 0;
    for (int i = 0; i < 8; i++) begin
      r.status = STATUS_OK;
      r.dword  = hash_state[i];
      r.index  = i[2:0];
      r.last   = (i == 7);
      pending_results = {pending_results, r};
    end
  endfunction

  task automatic report_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("MISMATCH at %0t: %s got %0h, wanted %0h", $time, field, got, want);
    fail_count++;
  endtask

  // Valid stays high from one item to the next when there is no gap, so it
  // is never lowered and raised in the same step.
  task automatic send_item(input logic kind, input logic [7:0] data);
    int gap;
    gap = steady ? 0 : pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= data;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    predict_item(kind, data);
    items_sent++;
  endtask

  task automatic wait_for_results();
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Byte extremes and single-bit patterns at the head of the message.
  task automatic test_edge_bytes();
    logic [7:0] pattern [16];
    pattern = '{8'h00, 8'hff, 8'h80, 8'h7f, 8'h01, 8'hfe, 8'h55, 8'haa,
                8'h0f, 8'hf0, 8'h02, 8'h40, 8'h10, 8'h08, 8'h04, 8'h20};
    steady = 1'b1;
    for (int i = 0; i < 16; i++) begin
      if (i == 8) steady = 1'b0;
      send_item(KIND_ABSORB, pattern[i]);
    end
  endtask

  // Random bytes up to a length whose tail exercises either the one-block
  // or the two-block padding path, crossing two block boundaries first.
  task automatic test_random_message();
    int tail;
    int msg_len;
    int n;
    case ($urandom_range(0, 4))
      0: tail = 55;
      1: tail = 56;
      2: tail = 63;
      3: tail = 64;
      default: tail = $urandom_range(1, 62);
    endcase
    msg_len = 128 + tail;
    n = 0;
    while (byte_total < msg_len) begin
      steady = (n >= 60 && n < 100);
      send_item(KIND_ABSORB, 8'($urandom_range(0, 255)));
      n++;
    end
    steady = 1'b0;
  endtask

  // The finish item is withdrawn once taken so that nothing else is offered
  // while the digest comes out.
  task automatic test_finish_digest();
    send_item(KIND_FINISH, 8'($urandom_range(0, 255)));
    s_axis_tvalid <= 1'b0;
    wait_for_results();
  endtask

  // Every item after the finish answers with a finalized error. The receiver
  // holds off for a long stretch so the block fills and stalls its input.
  task automatic test_after_finish();
    hold_req = 1'b1;
    wait (hold_active);
    steady = 1'b1;
    send_item(KIND_ABSORB, 8'h00);
    send_item(KIND_FINISH, 8'hff);
    late_items += 2;
    for (int i = 0; i < 60; i++) begin
      if (i == 6) steady = 1'b0;
      send_item(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
      late_items++;
    end
    s_axis_tvalid <= 1'b0;
    wait_for_results();
  endtask

  initial begin : result_sink
    int stall;
    m_axis_tready <= 1'b0;
    @(negedge rst);
    @(posedge clk);
    forever begin
      m_axis_tready <= 1'b1;
      repeat ($urandom_range(1, 16)) @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_active = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_active = 1'b0;
      end else begin
        stall = steady ? 0 : pick_gap();
        if (stall > 0) begin
          m_axis_tready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
    end
  end

  always @(posedge clk) begin : check_results
    digest_item_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      results_checked++;
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result, digest word", m_axis_tdata[31:0], 32'h0);
      end else begin
        want = pending_results.pop_front();
        if (m_axis_tuser !== want.status)
          report_mismatch("status", 32'(m_axis_tuser), 32'(want.status));
        if (m_axis_tdata[31:0] !== want.dword)
          report_mismatch("digest word", m_axis_tdata[31:0], want.dword);
        if (m_axis_tdata[34:32] !== want.index)
          report_mismatch("word index", 32'(m_axis_tdata[34:32]), 32'(want.index));
        if (m_axis_tdata[OUT_TDATA_W-1:35] !== '0)
          report_mismatch("tdata fill", 32'(m_axis_tdata[OUT_TDATA_W-1:35]), 32'h0);
        if (m_axis_tlast !== want.last)
          report_mismatch("last", 32'(m_axis_tlast), 32'(want.last));
      end
    end
  end

  initial begin : run_limit
    #6000000;
    $display("Timeout with %0d results still pending", pending_results.size());
    $display("status: fail");
    $finish;
  end

  initial begin
    rst           = 1'b1;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= 8'h00;
    s_axis_tuser  <= KIND_ABSORB;
    fail_count      = 0;
    results_checked = 0;
    items_sent      = 0;
    late_items      = 0;
    steady          = 1'b0;
    hold_req        = 1'b0;
    hold_active     = 1'b0;
    clear_hash();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_edge_bytes();
    test_random_message();
    test_finish_digest();
    test_after_finish();

    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Hashed a %0d-byte message and checked its digest, then %0d items after finish.",
             byte_total, late_items);
    $display("%0d items sent, %0d results checked, %0d mismatches.",
             items_sent, results_checked, fail_count);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

@@ sim.f @@
design/shs_pkg.sv
design/shs_round.sv
design/sha256_stream_hasher.sv
design/shs_checker.sv
test/tb_sha256_stream_hasher.sv
